/* design/itseg_pkg.sv */
// ----------------------------------------------------------------------------
// Isoline triangle segment package
// Shared widths, constants and the queue entry type of the segment core.
// ----------------------------------------------------------------------------
package itseg_pkg;

   localparam int COORD_WIDTH = 32;
   localparam int FRAC_BITS   = 16;
   // A tolerance of 1e-6 in least significant bits, rounded up.
   localparam int TOL_LSB     = ((1 << FRAC_BITS) + 999999) / 1000000;
   localparam int DIFF_WIDTH  = COORD_WIDTH + 1;
   localparam int NUM_LANES   = 6;
   localparam int CASE_WIDTH  = 3;
   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_WIDTH  = $clog2(QUEUE_DEPTH);

   localparam logic [CASE_WIDTH-1:0] CASE_MAX = CASE_WIDTH'(5);

   localparam int VERTEX_BITS = 4 * COORD_WIDTH;
   localparam int REQ_BITS    = 3 * VERTEX_BITS;
   localparam int RSP_BITS    = NUM_LANES * COORD_WIDTH;

   // x sits in the lowest bits.
   typedef struct packed {
      logic signed [COORD_WIDTH-1:0] scalar;
      logic signed [COORD_WIDTH-1:0] z;
      logic signed [COORD_WIDTH-1:0] y;
      logic signed [COORD_WIDTH-1:0] x;
   } vertex_type;

   typedef struct packed {
      vertex_type b;
      vertex_type a;
   } edge_type;

   typedef struct packed {
      logic [CASE_WIDTH-1:0] code;
      edge_type              e1;
      edge_type              e0;
   } entry_type;

   function automatic logic signed [COORD_WIDTH-1:0] coord_sel(vertex_type v, int k);
      logic signed [COORD_WIDTH-1:0] c;
      case (k)
         0:       c = v.x;
         1:       c = v.y;
         default: c = v.z;
      endcase
      return c;
   endfunction

endpackage

/* design/itseg_queue.sv */
// ----------------------------------------------------------------------------
// Segment work queue
// Short FIFO that parts the classifier from the interpolation pipeline.
// ----------------------------------------------------------------------------
module itseg_queue (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 push,
   input  itseg_pkg::entry_type push_data,
   output logic                 full,
   input  logic                 pop,
   output logic                 not_empty,
   output itseg_pkg::entry_type pop_data
);

   itseg_pkg::entry_type mem [itseg_pkg::QUEUE_DEPTH];
   logic [itseg_pkg::QPTR_WIDTH-1:0] wr_ptr_ff, wr_ptr_in;
   logic [itseg_pkg::QPTR_WIDTH-1:0] rd_ptr_ff, rd_ptr_in;
   logic [itseg_pkg::QPTR_WIDTH:0]   count_ff, count_in;
   logic                             do_push, do_pop;

   assign full      = (count_ff == (itseg_pkg::QPTR_WIDTH+1)'(itseg_pkg::QUEUE_DEPTH));
   assign not_empty = (count_ff != '0);
   assign pop_data  = mem[rd_ptr_ff];
   assign do_push   = push && !full;
   assign do_pop    = pop && not_empty;

   always_comb begin
      wr_ptr_in = do_push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = do_pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem[wr_ptr_ff] <= push_data;
      end
   end

endmodule

/* design/itseg_front.sv */
// ----------------------------------------------------------------------------
// Triangle classifier
// Sorts vertices above or below the level, drops triangles that do not
// straddle it and queues the two crossing edges of the others.
// ----------------------------------------------------------------------------
module itseg_front (
   input  logic                                     clock,
   input  logic                                     reset,
   input  logic signed [itseg_pkg::COORD_WIDTH-1:0] iso,
   input  logic                                     req_tvalid,
   output logic                                     req_tready,
   input  logic [itseg_pkg::REQ_BITS-1:0]           req_tdata,
   input  logic                                     q_pop,
   output logic                                     q_valid,
   output itseg_pkg::entry_type                     q_data
);

   itseg_pkg::vertex_type v [3];
   itseg_pkg::entry_type  entry;
   logic [2:0]            pat;
   logic                  on_level;
   logic                  straddle;
   logic                  full;

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         v[i] = itseg_pkg::vertex_type'(req_tdata[i*itseg_pkg::VERTEX_BITS +:
                                                  itseg_pkg::VERTEX_BITS]);
      end
      on_level = 1'b0;
      for (int i = 0; i < 3; i++) begin
         pat[2-i] = (v[i].scalar > iso);
         if (v[i].scalar == iso) begin
            on_level = 1'b1;
         end
      end
      straddle = !on_level && (pat != 3'b000) && (pat != 3'b111);

      entry.code = itseg_pkg::CASE_WIDTH'(pat - 3'd1);
      case (pat)
         3'b001: begin
            entry.e0 = '{a: v[0], b: v[2]};
            entry.e1 = '{a: v[1], b: v[2]};
         end
         3'b010, 3'b101: begin
            entry.e0 = '{a: v[1], b: v[0]};
            entry.e1 = '{a: v[1], b: v[2]};
         end
         3'b110: begin
            entry.e0 = '{a: v[2], b: v[1]};
            entry.e1 = '{a: v[2], b: v[0]};
         end
         default: begin
            entry.e0 = '{a: v[0], b: v[1]};
            entry.e1 = '{a: v[0], b: v[2]};
         end
      endcase
   end

   // A triangle without a crossing is taken and dropped here.
   assign req_tready = !full;

   itseg_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (req_tvalid && straddle),
      .push_data (entry),
      .full      (full),
      .pop       (q_pop),
      .not_empty (q_valid),
      .pop_data  (q_data)
   );

endmodule

/* design/itseg_back.sv */
// ----------------------------------------------------------------------------
// Edge interpolation pipeline
// Six lanes, one per output coordinate: difference stage, multiply stage,
// one restoring division step per stage, then the output register.
// ----------------------------------------------------------------------------
module itseg_back (
   input  logic                                     clock,
   input  logic                                     reset,
   input  logic signed [itseg_pkg::COORD_WIDTH-1:0] iso,
   input  logic                                     q_valid,
   input  itseg_pkg::entry_type                     q_data,
   output logic                                     q_pop,
   output logic                                     rsp_tvalid,
   input  logic                                     rsp_tready,
   output logic [itseg_pkg::RSP_BITS-1:0]           rsp_tdata,
   output logic [itseg_pkg::CASE_WIDTH-1:0]         rsp_tuser
);

   localparam int CW = itseg_pkg::COORD_WIDTH;
   localparam int DW = itseg_pkg::DIFF_WIDTH;
   localparam int NL = itseg_pkg::NUM_LANES;

   typedef struct packed {
      logic signed [CW-1:0] base;
      logic                 neg;
      logic [DW-1:0]        mag_da;
      logic [DW-1:0]        mag_dc;
      logic [DW-1:0]        dvs;
   } prep_type;

   typedef struct packed {
      logic signed [CW-1:0] base;
      logic                 neg;
      logic [DW-1:0]        rem;
      logic [DW-1:0]        numlo;
      logic [DW-1:0]        quo;
      logic [DW-1:0]        dvs;
   } lane_type;

   function automatic logic [DW-1:0] magn(logic signed [DW-1:0] d);
      return d[DW-1] ? DW'(-d) : DW'(d);
   endfunction

   function automatic lane_type div_step(lane_type x);
      logic [DW:0] trial;
      lane_type    y;
      y       = x;
      trial   = {x.rem, x.numlo[DW-1]};
      y.numlo = {x.numlo[DW-2:0], 1'b0};
      if (trial >= {1'b0, x.dvs}) begin
         y.rem = DW'(trial - {1'b0, x.dvs});
         y.quo = {x.quo[DW-2:0], 1'b1};
      end else begin
         y.rem = trial[DW-1:0];
         y.quo = {x.quo[DW-2:0], 1'b0};
      end
      return y;
   endfunction

   logic                     adv;
   prep_type                 prep_in [NL];
   prep_type                 prep_ff [NL];
   logic                     prep_valid_ff;
   logic [2:0]               prep_code_ff;
   lane_type                 mul_ff [NL];
   logic                     mul_valid_ff;
   logic [2:0]               mul_code_ff;
   lane_type                 div_ff [DW][NL];
   logic [DW-1:0]            div_valid_ff;
   logic [2:0]               div_code_ff [DW];
   logic [itseg_pkg::RSP_BITS-1:0] rsp_data_in;

   assign adv   = !rsp_tvalid || rsp_tready;
   assign q_pop = adv;

   always_comb begin
      itseg_pkg::edge_type   ed;
      logic signed [DW-1:0]  da, db, dv, dc;
      logic                  use_a, use_b;
      logic signed [CW-1:0]  ca, cb;
      for (int e = 0; e < 2; e++) begin
         ed = (e == 0) ? q_data.e0 : q_data.e1;
         da = DW'(iso) - DW'(ed.a.scalar);
         db = DW'(iso) - DW'(ed.b.scalar);
         dv = DW'(ed.b.scalar) - DW'(ed.a.scalar);
         use_a = magn(da) < DW'(itseg_pkg::TOL_LSB);
         use_b = !use_a && (magn(db) < DW'(itseg_pkg::TOL_LSB));
         if (!use_a && !use_b && (magn(dv) < DW'(itseg_pkg::TOL_LSB))) begin
            use_a = 1'b1;
         end
         for (int k = 0; k < 3; k++) begin
            ca = itseg_pkg::coord_sel(ed.a, k);
            cb = itseg_pkg::coord_sel(ed.b, k);
            dc = DW'(cb) - DW'(ca);
            // Snapped ends divide zero by one so every lane runs the same way.
            if (use_a || use_b) begin
               prep_in[e*3+k].base   = use_b ? cb : ca;
               prep_in[e*3+k].neg    = 1'b0;
               prep_in[e*3+k].mag_da = '0;
               prep_in[e*3+k].mag_dc = '0;
               prep_in[e*3+k].dvs    = DW'(1);
            end else begin
               prep_in[e*3+k].base   = ca;
               prep_in[e*3+k].neg    = (da[DW-1] != dc[DW-1]) != dv[DW-1];
               prep_in[e*3+k].mag_da = magn(da);
               prep_in[e*3+k].mag_dc = magn(dc);
               prep_in[e*3+k].dvs    = magn(dv);
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         prep_valid_ff <= 1'b0;
         mul_valid_ff  <= 1'b0;
         div_valid_ff  <= '0;
         rsp_tvalid    <= 1'b0;
      end else if (adv) begin
         prep_valid_ff <= q_valid;
         mul_valid_ff  <= prep_valid_ff;
         div_valid_ff  <= {div_valid_ff[DW-2:0], mul_valid_ff};
         rsp_tvalid    <= div_valid_ff[DW-1];
      end
   end

   always_ff @(posedge clock) begin
      logic [2*DW-1:0] prod;
      if (adv) begin
         prep_code_ff <= q_data.code;
         mul_code_ff  <= prep_code_ff;
         for (int l = 0; l < NL; l++) begin
            prep_ff[l] <= prep_in[l];
            prod = (2*DW)'(prep_ff[l].mag_da) * (2*DW)'(prep_ff[l].mag_dc);
            mul_ff[l].base  <= prep_ff[l].base;
            mul_ff[l].neg   <= prep_ff[l].neg;
            mul_ff[l].rem   <= prod[2*DW-1:DW];
            mul_ff[l].numlo <= prod[DW-1:0];
            mul_ff[l].quo   <= '0;
            mul_ff[l].dvs   <= prep_ff[l].dvs;
         end
      end
   end

   for (genvar s = 0; s < DW; s++) begin : g_div
      always_ff @(posedge clock) begin
         if (adv) begin
            div_code_ff[s] <= (s == 0) ? mul_code_ff : div_code_ff[(s == 0) ? 0 : s-1];
            for (int l = 0; l < NL; l++) begin
               div_ff[s][l] <= div_step((s == 0) ? mul_ff[l] : div_ff[(s == 0) ? 0 : s-1][l]);
            end
         end
      end
   end

   always_comb begin
      logic signed [DW:0] r;
      for (int l = 0; l < NL; l++) begin
         r = div_ff[DW-1][l].neg
             ? (DW+1)'(div_ff[DW-1][l].base) - (DW+1)'({1'b0, div_ff[DW-1][l].quo})
             : (DW+1)'(div_ff[DW-1][l].base) + (DW+1)'({1'b0, div_ff[DW-1][l].quo});
         rsp_data_in[l*CW +: CW] = r[CW-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         rsp_tdata <= rsp_data_in;
         rsp_tuser <= div_code_ff[DW-1];
      end
   end

endmodule

/* design/isoline_triangle_segment_core.sv */
// ----------------------------------------------------------------------------
// Isoline triangle segment core
// Marching-triangles segment extraction for one triangle per transfer.
// ----------------------------------------------------------------------------
// A triangle is taken every cycle while the four-entry queue has room; one
// that does not straddle the level yields no transfer. A segment passes
// from the queue through the difference, multiply and 33 division stages
// and the output register of the interpolation pipeline, and the pipeline
// holds while the result waits to be taken. Write iso_level only while the
// core is idle.
module isoline_triangle_segment_core (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  csr_valid,
   output logic                                  csr_ready,
   input  logic [itseg_pkg::COORD_WIDTH-1:0]     csr_wdata,
   input  logic                                  req_tvalid,
   output logic                                  req_tready,
   // v0_x, v0_y, v0_z, v0_scalar, v1_x .. v1_scalar, v2_x .. v2_scalar
   input  logic [itseg_pkg::REQ_BITS-1:0]        req_tdata,
   output logic                                  rsp_tvalid,
   input  logic                                  rsp_tready,
   // start_x, start_y, start_z, end_x, end_y, end_z
   output logic [itseg_pkg::RSP_BITS-1:0]        rsp_tdata,
   // crossing_case
   output logic [itseg_pkg::CASE_WIDTH-1:0]      rsp_tuser
);

   logic signed [itseg_pkg::COORD_WIDTH-1:0] iso_ff;
   logic                                     q_valid, q_pop;
   itseg_pkg::entry_type                     q_data;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         iso_ff <= '0;
      end else if (csr_valid) begin
         iso_ff <= csr_wdata;
      end
   end

   itseg_front u_front (
      .clock      (clock),
      .reset      (reset),
      .iso        (iso_ff),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .q_pop      (q_pop),
      .q_valid    (q_valid),
      .q_data     (q_data)
   );

   itseg_back u_back (
      .clock      (clock),
      .reset      (reset),
      .iso        (iso_ff),
      .q_valid    (q_valid),
      .q_data     (q_data),
      .q_pop      (q_pop),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   a_case_range : assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (rsp_tuser <= itseg_pkg::CASE_MAX))
      else $error("crossing case out of range");

   a_reset_quiet : assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("result valid right after reset");

   a_ready_after_take : assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tready) |-> q_pop)
      else $error("pipeline held while its result was taken");

endmodule
